// File: rtl/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types and constants of the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int NUM_EL   = 9;   // matrix elements, row-major
    localparam int FRAC_W   = 14;  // fraction bits of the result
    localparam int Q_W      = 15;  // quotient bits, covers 0..16384
    localparam int S_W      = 33;  // squared norm, up to 2^32
    localparam int N_W      = 34;  // signed numerators
    localparam int D_W      = 34;  // divisor 2*s
    localparam int REM_W    = 48;  // dividend mag*2^15 + s
    localparam int DIV_DEPTH = Q_W;

    localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

    // products of the quaternion parts
    typedef struct packed {
        logic signed [31:0] ww;
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] zz;
        logic signed [31:0] xy;
        logic signed [31:0] zw;
        logic signed [31:0] xz;
        logic signed [31:0] yw;
        logic signed [31:0] yz;
        logic signed [31:0] xw;
    } prod_t;

    // numerators and squared norm
    typedef struct packed {
        logic signed [NUM_EL-1:0][N_W-1:0] num;
        logic [S_W-1:0]                    s;
    } sum_t;

    // one division lane
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             neg;
    } lane_t;

    // word moving through the divider stages
    typedef struct packed {
        lane_t [NUM_EL-1:0] lane;
        logic [D_W-1:0]     d;
        logic               zero;
    } div_t;

endpackage

// File: rtl/qrm_front.sv
// ----------------------------------------------------------------------------
// qrm_front
// Three stages: products, numerator sums, then magnitude and dividend setup.
// ----------------------------------------------------------------------------
module qrm_front import qrm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        up_ready,
    input  logic [15:0] q_w,
    input  logic [15:0] q_x,
    input  logic [15:0] q_y,
    input  logic [15:0] q_z,
    output logic        out_valid,
    input  logic        down_ready,
    output div_t        out_data
);

    logic  v1_reg, v2_reg, v3_reg;
    logic  rdy1, rdy2, rdy3;
    prod_t p_reg, p_next;
    sum_t  sm_reg, sm_next;
    div_t  d_reg, d_next;

    // per-stage ready, bubbles collapse
    assign rdy3     = !v3_reg || down_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign up_ready = rdy1;

    // stage one products
    always_comb begin
        logic signed [15:0] w, x, y, z;
        w = q_w;
        x = q_x;
        y = q_y;
        z = q_z;
        p_next.ww = w * w;
        p_next.xx = x * x;
        p_next.yy = y * y;
        p_next.zz = z * z;
        p_next.xy = x * y;
        p_next.zw = z * w;
        p_next.xz = x * z;
        p_next.yw = y * w;
        p_next.yz = y * z;
        p_next.xw = x * w;
    end

    // stage two numerators and norm
    always_comb begin
        logic signed [N_W-1:0] ww, xx, yy, zz, xy, zw, xz, yw, yz, xw;
        ww = N_W'(p_reg.ww);
        xx = N_W'(p_reg.xx);
        yy = N_W'(p_reg.yy);
        zz = N_W'(p_reg.zz);
        xy = N_W'(p_reg.xy);
        zw = N_W'(p_reg.zw);
        xz = N_W'(p_reg.xz);
        yw = N_W'(p_reg.yw);
        yz = N_W'(p_reg.yz);
        xw = N_W'(p_reg.xw);
        sm_next.num[0] = ww + xx - yy - zz;
        sm_next.num[1] = (xy - zw) <<< 1;
        sm_next.num[2] = (xz + yw) <<< 1;
        sm_next.num[3] = (xy + zw) <<< 1;
        sm_next.num[4] = ww - xx + yy - zz;
        sm_next.num[5] = (yz - xw) <<< 1;
        sm_next.num[6] = (xz - yw) <<< 1;
        sm_next.num[7] = (yz + xw) <<< 1;
        sm_next.num[8] = ww - xx - yy + zz;
        sm_next.s      = S_W'(ww + xx + yy + zz);
    end

    // stage three sign, magnitude and dividend
    always_comb begin
        logic [N_W-1:0] mag;
        for (int i = 0; i < NUM_EL; i++) begin
            d_next.lane[i].neg = sm_reg.num[i][N_W-1];
            mag = sm_reg.num[i][N_W-1] ? N_W'(-sm_reg.num[i]) : N_W'(sm_reg.num[i]);
            d_next.lane[i].rem = {mag[S_W-1:0], 15'd0} + REM_W'(sm_reg.s);
            d_next.lane[i].q   = '0;
        end
        d_next.d    = {sm_reg.s, 1'b0};
        d_next.zero = (sm_reg.s == '0);
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
        if (rdy1) p_reg  <= p_next;
        if (rdy2) sm_reg <= sm_next;
        if (rdy3) d_reg  <= d_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = d_reg;

endmodule

// File: rtl/qrm_div_stage.sv
// ----------------------------------------------------------------------------
// qrm_div_stage
// One restoring division step, one quotient bit, for all nine lanes.
// ----------------------------------------------------------------------------
module qrm_div_stage import qrm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [3:0] sh,
    input  logic       in_valid,
    output logic       up_ready,
    input  div_t       in_data,
    output logic       out_valid,
    input  logic       down_ready,
    output div_t       out_data
);

    logic valid_reg;
    div_t data_reg, data_next;

    assign up_ready = !valid_reg || down_ready;

    // trial subtract of the shifted divisor
    always_comb begin
        logic [REM_W-1:0] trial;
        logic             ge;
        trial     = REM_W'(in_data.d) << sh;
        data_next = in_data;
        for (int i = 0; i < NUM_EL; i++) begin
            ge = (in_data.lane[i].rem >= trial);
            data_next.lane[i].rem = ge ? in_data.lane[i].rem - trial : in_data.lane[i].rem;
            data_next.lane[i].q   = {in_data.lane[i].q[Q_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
        if (up_ready) data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/qrm_out.sv
// ----------------------------------------------------------------------------
// qrm_out
// Output register: clamp, sign restore and identity for a zero quaternion.
// ----------------------------------------------------------------------------
module qrm_out import qrm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         up_ready,
    input  div_t         in_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,
    output logic [0:0]   m_tuser
);

    logic         valid_reg;
    logic [143:0] data_reg, data_next;
    logic         zero_reg;

    assign up_ready = !valid_reg || m_tready;

    // element formatting
    always_comb begin
        logic [Q_W-1:0] qc;
        logic [15:0]    e;
        for (int i = 0; i < NUM_EL; i++) begin
            qc = (in_data.lane[i].q > ONE_Q14) ? ONE_Q14 : in_data.lane[i].q;
            e  = in_data.lane[i].neg ? 16'(-{1'b0, qc}) : {1'b0, qc};
            if (in_data.zero) begin
                e = (i % 4 == 0) ? {1'b0, ONE_Q14} : 16'd0;
            end
            data_next[i*16 +: 16] = e;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
        if (up_ready) begin
            data_reg <= data_next;
            zero_reg <= in_data.zero;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = zero_reg;

endmodule

// File: rtl/quaternion_to_rotation_matrix_unit.sv
// Pipeline: 3 setup stages, 15 divider stages and 1 output register
// between input word and result word.
// Throughput: one word per cycle unless m_tready stalls the pipeline; the 15-stage
// restoring divider takes one quotient bit per stage for all nine elements in parallel.
// Reset: aresetn synchronous active low clears every stage valid bit.
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit
// Normalizes a Q2.14 quaternion and emits its rotation matrix in Q1.14.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit import qrm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // q_w, q_x, q_y, q_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic [0:0]   m_tuser    // zero_norm
);

    div_t stg_data  [0:DIV_DEPTH];
    logic stg_valid [0:DIV_DEPTH];
    logic stg_ready [0:DIV_DEPTH];

    // setup stages
    qrm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .up_ready   (s_tready),
        .q_w        (s_tdata[15:0]),
        .q_x        (s_tdata[31:16]),
        .q_y        (s_tdata[47:32]),
        .q_z        (s_tdata[63:48]),
        .out_valid  (stg_valid[0]),
        .down_ready (stg_ready[0]),
        .out_data   (stg_data[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar i = 0; i < DIV_DEPTH; i++) begin : g_div
        qrm_div_stage u_stage (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .sh         (4'(DIV_DEPTH - 1 - i)),
            .in_valid   (stg_valid[i]),
            .up_ready   (stg_ready[i]),
            .in_data    (stg_data[i]),
            .out_valid  (stg_valid[i+1]),
            .down_ready (stg_ready[i+1]),
            .out_data   (stg_data[i+1])
        );
    end

    // output register
    qrm_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stg_valid[DIV_DEPTH]),
        .up_ready (stg_ready[DIV_DEPTH]),
        .in_data  (stg_data[DIV_DEPTH]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
